// ===== hdl/irct_pkg.sv =====
package irct_pkg;

  // Line regions (3-bit state vector)
  localparam logic [2:0] R_LINE_START  = 3'd0;
  localparam logic [2:0] R_TAGS        = 3'd1;
  localparam logic [2:0] R_AFTER_TAGS  = 3'd2;
  localparam logic [2:0] R_PREFIX      = 3'd3;
  localparam logic [2:0] R_COMMAND     = 3'd4;
  localparam logic [2:0] R_PARAM_START = 3'd5;
  localparam logic [2:0] R_PARAM       = 3'd6;
  localparam logic [2:0] R_TRAILING    = 3'd7;

  // Result classes
  localparam logic [3:0] C_TAG_KEY   = 4'd0;
  localparam logic [3:0] C_TAG_VAL   = 4'd1;
  localparam logic [3:0] C_TAG_END   = 4'd2;
  localparam logic [3:0] C_PFX       = 4'd3;
  localparam logic [3:0] C_PFX_END   = 4'd4;
  localparam logic [3:0] C_CMD       = 4'd5;
  localparam logic [3:0] C_CMD_END   = 4'd6;
  localparam logic [3:0] C_PARAM     = 4'd7;
  localparam logic [3:0] C_PARAM_END = 4'd8;
  localparam logic [3:0] C_TRAIL     = 4'd9;
  localparam logic [3:0] C_LINE_END  = 4'd10;

  // Prefix segments
  localparam logic [1:0] SEG_NICK = 2'd0;
  localparam logic [1:0] SEG_SEP  = 2'd1;
  localparam logic [1:0] SEG_USER = 2'd2;
  localparam logic [1:0] SEG_HOST = 2'd3;

  // Line status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_TAGS_OPEN  = 3'd2;
  localparam logic [2:0] ST_PFX_OPEN   = 3'd3;
  localparam logic [2:0] ST_TOO_MANY   = 3'd4;

  // Characters
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Per-line control state
  typedef struct packed {
    logic [2:0] region;
    logic       in_tag_value;
    logic       tag_part_nonempty;
    logic       escape_pending;
    logic [1:0] prefix_part;
    logic       at_before_bang;
    logic       line_nonempty;
    logic       param_overflow;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    region:            R_LINE_START,
    in_tag_value:      1'b0,
    tag_part_nonempty: 1'b0,
    escape_pending:    1'b0,
    prefix_part:       SEG_NICK,
    at_before_bang:    1'b0,
    line_nonempty:     1'b0,
    param_overflow:    1'b0
  };

  // One result item, without the last-of-run flag
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] cls;
    logic [1:0] seg;
    logic [4:0] idx;
    logic       split;
    logic [2:0] status;
  } res_t;

  function automatic res_t mk_res(input logic [7:0] d, input logic [3:0] c,
                                  input logic [1:0] s, input logic [4:0] i,
                                  input logic sp, input logic [2:0] stt);
    res_t r;
    r.data   = d;
    r.cls    = c;
    r.seg    = s;
    r.idx    = i;
    r.split  = sp;
    r.status = stt;
    return r;
  endfunction

endpackage

// ===== hdl/irc_line_tokenizer.sv =====
// A byte passes the input register, then the result pair register. One byte
// per cycle is taken while out_ready is high and no byte yields two results;
// a byte or line end with two results holds the pair register until both are
// taken. CR and LF yield nothing. Limit: the one-result-per-cycle output port.
// Reset (rst, synchronous): empties both registers and returns to line start.
module irc_line_tokenizer import irct_pkg::*; #(
  parameter int MAX_PARAMS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [3:0] field_class,
  output logic [1:0] prefix_segment,
  output logic [4:0] param_index,
  output logic       split_valid,
  output logic [2:0] line_status,
  output logic       last_of_run
);

  localparam int CW = $clog2(MAX_PARAMS + 1);

  logic          in_full;
  logic [7:0]    in_data;
  logic          in_eol;
  ctl_t          st;
  ctl_t          st_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  res_t          r0;
  res_t          r1;
  logic [1:0]    nres;
  res_t          e0;
  res_t          e1;
  logic [1:0]    pend;
  logic [1:0]    pend_next;
  logic          ptr;
  logic          ptr_next;
  logic          out_take;
  logic          pair_free;
  logic          adv;
  res_t          cur;

  irct_step #(
    .MAX_PARAMS (MAX_PARAMS),
    .CW         (CW)
  ) u_step (
    .st       (st),
    .cnt      (cnt),
    .data     (in_data),
    .eol      (in_eol),
    .st_next  (st_next),
    .cnt_next (cnt_next),
    .r0       (r0),
    .r1       (r1),
    .nres     (nres)
  );

  // Handshake and advance control
  assign out_valid = (pend != 2'd0);
  assign out_take  = out_valid & out_ready;
  assign pair_free = (pend == 2'd0) || (out_take && pend == 2'd1);
  assign adv       = in_full & pair_free;
  assign in_ready  = ~in_full | adv;

  always_comb begin
    pend_next = pend;
    ptr_next  = ptr;
    if (out_take) begin
      if (pend == 2'd2) begin
        pend_next = 2'd1;
        ptr_next  = 1'b1;
      end else begin
        pend_next = 2'd0;
      end
    end
    if (adv && nres != 2'd0) begin
      pend_next = nres;
      ptr_next  = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data <= data_byte;
      in_eol  <= end_of_line;
    end
  end

  // Line state and result pair
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= CTL_RESET;
      cnt  <= '0;
      pend <= 2'd0;
      ptr  <= 1'b0;
    end else begin
      pend <= pend_next;
      ptr  <= ptr_next;
      if (adv) begin
        st  <= st_next;
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && nres != 2'd0) begin
      e0 <= r0;
      e1 <= r1;
    end
  end

  // Output fields
  assign cur            = ptr ? e1 : e0;
  assign out_byte       = cur.data;
  assign field_class    = cur.cls;
  assign prefix_segment = cur.seg;
  assign param_index    = cur.idx;
  assign split_valid    = cur.split;
  assign line_status    = cur.status;
  assign last_of_run    = (pend == 2'd1);

endmodule

// ===== hdl/irct_step.sv =====
module irct_step import irct_pkg::*; #(
  parameter int MAX_PARAMS = 16,
  parameter int CW = $clog2(MAX_PARAMS + 1)
) (
  input  ctl_t          st,
  input  logic [CW-1:0] cnt,
  input  logic [7:0]    data,
  input  logic          eol,
  output ctl_t          st_next,
  output logic [CW-1:0] cnt_next,
  output res_t          r0,
  output res_t          r1,
  output logic [1:0]    nres
);

  logic          at_max;
  logic [CW-1:0] cnt_bump;
  logic          ovf_bump;
  logic [4:0]    idx;
  logic [4:0]    idx_bump;
  logic [7:0]    upper;
  logic [7:0]    unesc;
  logic [1:0]    seg;

  // Saturating parameter count
  assign at_max   = (cnt >= CW'(MAX_PARAMS));
  assign cnt_bump = at_max ? cnt : cnt + CW'(1);
  assign ovf_bump = st.param_overflow | at_max;
  assign idx      = 5'(cnt);
  assign idx_bump = 5'(cnt_bump);

  assign upper = (data >= CH_LC_A && data <= CH_LC_Z) ? data - CASE_OFS : data;

  // Tag value escape mapping
  always_comb begin
    case (data)
      CH_COLON: unesc = CH_SEMI;
      CH_S:     unesc = CH_SPACE;
      CH_R:     unesc = CH_CR;
      CH_N:     unesc = CH_LF;
      default:  unesc = data;
    endcase
  end

  // Next state and results for one transaction
  always_comb begin
    st_next  = st;
    cnt_next = cnt;
    r0       = '0;
    r1       = '0;
    nres     = 2'd0;
    seg      = st.prefix_part;
    if (eol) begin
      // Line end summary, then clear for the next line
      st_next  = CTL_RESET;
      cnt_next = '0;
      nres     = 2'd1;
      if (!st.line_nonempty) begin
        r0 = mk_res(8'h00, C_LINE_END, SEG_NICK, idx, 1'b0, ST_EMPTY);
      end else if (st.region == R_TAGS) begin
        r0 = mk_res(8'h00, C_LINE_END, SEG_NICK, idx, 1'b0, ST_TAGS_OPEN);
      end else if (st.region == R_PREFIX) begin
        r0 = mk_res(8'h00, C_LINE_END, SEG_NICK, idx, 1'b0, ST_PFX_OPEN);
      end else if (st.region == R_COMMAND || st.region == R_AFTER_TAGS) begin
        r0   = mk_res(8'h00, C_CMD_END, SEG_NICK, 5'd0, 1'b0, ST_OK);
        r1   = mk_res(8'h00, C_LINE_END, SEG_NICK, idx, 1'b0,
                      st.param_overflow ? ST_TOO_MANY : ST_OK);
        nres = 2'd2;
      end else if (st.region == R_PARAM) begin
        r0   = mk_res(8'h00, C_PARAM_END, SEG_NICK, idx, 1'b0, ST_OK);
        r1   = mk_res(8'h00, C_LINE_END, SEG_NICK, idx_bump, 1'b0,
                      ovf_bump ? ST_TOO_MANY : ST_OK);
        nres = 2'd2;
      end else if (st.region == R_TRAILING) begin
        r0 = mk_res(8'h00, C_LINE_END, SEG_NICK, idx_bump, 1'b0,
                    ovf_bump ? ST_TOO_MANY : ST_OK);
      end else begin
        r0 = mk_res(8'h00, C_LINE_END, SEG_NICK, idx, 1'b0,
                    st.param_overflow ? ST_TOO_MANY : ST_OK);
      end
    end else if (data != CH_CR && data != CH_LF) begin
      st_next.line_nonempty = 1'b1;
      case (st.region)
        R_TAGS: begin
          if (data == CH_SPACE || data == CH_SEMI) begin
            // End of tag part; a pending backslash is emitted literally
            if (st.tag_part_nonempty) begin
              if (st.escape_pending) begin
                r0   = mk_res(CH_BSL, C_TAG_VAL, SEG_NICK, 5'd0, 1'b0, ST_OK);
                r1   = mk_res(8'h00, C_TAG_END, SEG_NICK, 5'd0, 1'b0, ST_OK);
                nres = 2'd2;
              end else begin
                r0   = mk_res(8'h00, C_TAG_END, SEG_NICK, 5'd0, 1'b0, ST_OK);
                nres = 2'd1;
              end
            end
            st_next.in_tag_value      = 1'b0;
            st_next.tag_part_nonempty = 1'b0;
            st_next.escape_pending    = 1'b0;
            if (data == CH_SPACE) begin
              st_next.region = R_AFTER_TAGS;
            end
          end else if (!st.in_tag_value) begin
            st_next.tag_part_nonempty = 1'b1;
            if (data == CH_EQ) begin
              st_next.in_tag_value = 1'b1;
            end else begin
              r0   = mk_res(data, C_TAG_KEY, SEG_NICK, 5'd0, 1'b0, ST_OK);
              nres = 2'd1;
            end
          end else if (st.escape_pending) begin
            st_next.escape_pending = 1'b0;
            r0   = mk_res(unesc, C_TAG_VAL, SEG_NICK, 5'd0, 1'b0, ST_OK);
            nres = 2'd1;
          end else if (data == CH_BSL) begin
            st_next.escape_pending = 1'b1;
          end else begin
            r0   = mk_res(data, C_TAG_VAL, SEG_NICK, 5'd0, 1'b0, ST_OK);
            nres = 2'd1;
          end
        end
        R_PREFIX: begin
          if (data == CH_SPACE) begin
            r0 = mk_res(8'h00, C_PFX_END, SEG_NICK, 5'd0,
                        st.prefix_part == SEG_HOST && !st.at_before_bang, ST_OK);
            nres = 2'd1;
            st_next.region = R_COMMAND;
          end else begin
            // First '!' then '@' split nick, user and host
            if (!st.at_before_bang) begin
              if (data == CH_BANG && st.prefix_part == SEG_NICK) begin
                seg = SEG_SEP;
                st_next.prefix_part = SEG_USER;
              end else if (data == CH_AT && st.prefix_part == SEG_USER) begin
                seg = SEG_SEP;
                st_next.prefix_part = SEG_HOST;
              end else if (data == CH_AT && st.prefix_part == SEG_NICK) begin
                st_next.at_before_bang = 1'b1;
                seg = SEG_NICK;
              end
            end else begin
              seg = SEG_NICK;
            end
            r0   = mk_res(data, C_PFX, seg, 5'd0, 1'b0, ST_OK);
            nres = 2'd1;
          end
        end
        R_PARAM_START: begin
          if (data == CH_COLON) begin
            st_next.region = R_TRAILING;
          end else if (data == CH_SPACE) begin
            // Doubled space: empty parameter
            r0   = mk_res(8'h00, C_PARAM_END, SEG_NICK, idx, 1'b0, ST_OK);
            nres = 2'd1;
            cnt_next = cnt_bump;
            st_next.param_overflow = ovf_bump;
          end else begin
            r0   = mk_res(data, C_PARAM, SEG_NICK, idx, 1'b0, ST_OK);
            nres = 2'd1;
            st_next.region = R_PARAM;
          end
        end
        R_PARAM: begin
          nres = 2'd1;
          if (data == CH_SPACE) begin
            r0 = mk_res(8'h00, C_PARAM_END, SEG_NICK, idx, 1'b0, ST_OK);
            cnt_next = cnt_bump;
            st_next.param_overflow = ovf_bump;
            st_next.region = R_PARAM_START;
          end else begin
            r0 = mk_res(data, C_PARAM, SEG_NICK, idx, 1'b0, ST_OK);
          end
        end
        R_TRAILING: begin
          r0   = mk_res(data, C_TRAIL, SEG_NICK, idx, 1'b0, ST_OK);
          nres = 2'd1;
        end
        default: begin
          // Line start, after tags, or command
          if (st.region == R_LINE_START && data == CH_AT) begin
            st_next.region = R_TAGS;
          end else if ((st.region == R_LINE_START || st.region == R_AFTER_TAGS) &&
                       data == CH_COLON) begin
            st_next.region = R_PREFIX;
          end else if (data == CH_SPACE) begin
            r0   = mk_res(8'h00, C_CMD_END, SEG_NICK, 5'd0, 1'b0, ST_OK);
            nres = 2'd1;
            st_next.region = R_PARAM_START;
          end else begin
            r0   = mk_res(upper, C_CMD, SEG_NICK, 5'd0, 1'b0, ST_OK);
            nres = 2'd1;
            st_next.region = R_COMMAND;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/irct_checker.sv =====
module irct_checker import irct_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [3:0] field_class,
  input logic [1:0] prefix_segment,
  input logic       last_of_run
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(field_class) && $stable(last_of_run))
    else $error("result changed while stalled");

  // Marker results carry no character
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (field_class == C_TAG_END || field_class == C_PFX_END ||
      field_class == C_CMD_END || field_class == C_PARAM_END ||
      field_class == C_LINE_END) |-> out_byte == 8'h00)
    else $error("marker result with nonzero byte");

  // Only prefix bytes carry a segment
  a_seg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_class != C_PFX |-> prefix_segment == SEG_NICK)
    else $error("segment set outside prefix");

  // Line end is always the final result of its transaction
  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_class == C_LINE_END |-> last_of_run)
    else $error("line end not last of run");

  // The second result of a pair follows at once
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("second result missing");

endmodule

bind irc_line_tokenizer irct_checker u_irct_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .field_class    (field_class),
  .prefix_segment (prefix_segment),
  .last_of_run    (last_of_run)
);
